### design/sfe_pkg.sv
// Shared types and constants for the SPI slave frame engine.
package sfe_pkg;

  typedef enum logic [1:0] {
    CMD_HOST_BYTE   = 2'd0,
    CMD_MASTER_BYTE = 2'd1,
    CMD_SEL_FALL    = 2'd2,
    CMD_SEL_RISE    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_TX      = 2'd1,
    KIND_STATUS  = 2'd2
  } kind_t;

  localparam logic [7:0] HDR_MASK = 8'hf0;
  localparam logic [7:0] HDR_MARK = 8'h50;
  localparam logic [7:0] CNT_MASK = 8'h0f;
  localparam logic [7:0] PAD_BYTE = 8'hff;

  // One result on its way to the output register.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       use_mem;     // byte comes from the send queue read port
    logic       last;
    logic       irq;
    logic       accepted;
    logic       reset_pulse;
  } elem_t;

endpackage

### design/sfe_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/sfe_proc.sv
// Event processor: link, header and queue state, one event per fire.
module sfe_proc #(
  parameter int QUEUE_DEPTH   = 1024,
  parameter int FRAME_PAYLOAD = 7
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           fire,
  input  logic [1:0]                     command,
  input  logic [7:0]                     data,
  output sfe_pkg::elem_t                 elem,
  output logic                           start,
  output logic [$clog2(FRAME_PAYLOAD+1)-1:0] start_n,
  output logic [$clog2(QUEUE_DEPTH)-1:0] start_head,
  output logic                           start_irq,
  output logic                           wr_en,
  output logic [$clog2(QUEUE_DEPTH)-1:0] wr_addr,
  output logic [7:0]                     wr_data
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int IW = $clog2(FRAME_PAYLOAD + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(QUEUE_DEPTH - 1);
  localparam logic [AW:0]   DEPTH_W   = (AW+1)'(QUEUE_DEPTH);
  localparam logic [CW-1:0] FULL_CNT  = CW'(QUEUE_DEPTH);
  localparam logic [CW-1:0] FP_CNT    = CW'(FRAME_PAYLOAD);
  localparam logic [3:0]    FP_NIB    = 4'(FRAME_PAYLOAD);

  logic          link_up_r, link_up_nxt;
  logic          await_r, await_nxt;
  logic [IW-1:0] pay_left_r, pay_left_nxt;
  logic          rst_pend_r, rst_pend_nxt;
  logic          irq_r, irq_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;

  sfe_pkg::cmd_t cmd;
  logic [IW-1:0] take_n;
  logic [AW:0]   head_sum;
  logic [7:0]    hdr_field;
  logic          hdr_ok;

  assign cmd       = sfe_pkg::cmd_t'(command);
  assign take_n    = (count_r > FP_CNT) ? IW'(FRAME_PAYLOAD) : IW'(count_r);
  assign head_sum  = {1'b0, head_r} + (AW+1)'(take_n);
  assign hdr_field = data & sfe_pkg::HDR_MASK;
  assign hdr_ok    = (hdr_field == sfe_pkg::HDR_MARK)
                  && ((data[3:0] & sfe_pkg::CNT_MASK[3:0]) <= FP_NIB);

  assign start_n    = take_n;
  assign start_head = head_r;
  assign wr_addr    = tail_r;
  assign wr_data    = data;

  always_comb begin
    link_up_nxt  = link_up_r;
    await_nxt    = await_r;
    pay_left_nxt = pay_left_r;
    rst_pend_nxt = rst_pend_r;
    irq_nxt      = irq_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    count_nxt    = count_r;
    start        = 1'b0;
    start_irq    = irq_r;
    wr_en        = 1'b0;

    elem.kind        = sfe_pkg::KIND_STATUS;
    elem.data        = 8'h00;
    elem.use_mem     = 1'b0;
    elem.last        = 1'b1;
    elem.accepted    = 1'b0;
    elem.reset_pulse = 1'b0;

    if (!link_up_r) begin
      link_up_nxt = fire ? 1'b1 : link_up_r;
    end else begin
      case (cmd)
        sfe_pkg::CMD_HOST_BYTE: begin
          irq_nxt = fire ? 1'b1 : irq_r;
          if (count_r < FULL_CNT) begin
            elem.accepted = 1'b1;
            wr_en         = fire;
            if (fire) begin
              tail_nxt  = (tail_r == LAST_ADDR) ? '0 : tail_r + AW'(1);
              count_nxt = count_r + CW'(1);
            end
          end
        end
        sfe_pkg::CMD_MASTER_BYTE: begin
          if (await_r) begin
            if (hdr_ok) begin
              await_nxt    = 1'b0;
              pay_left_nxt = IW'(data[3:0]);
              rst_pend_nxt = 1'b0;
            end else begin
              rst_pend_nxt = 1'b1;
            end
          end else if (pay_left_r != '0) begin
            pay_left_nxt = pay_left_r - IW'(1);
            elem.kind    = sfe_pkg::KIND_PAYLOAD;
            elem.data    = data;
          end
          if (!fire) begin
            await_nxt    = await_r;
            pay_left_nxt = pay_left_r;
            rst_pend_nxt = rst_pend_r;
          end
        end
        sfe_pkg::CMD_SEL_FALL: begin
          // header leaves here, the payload bytes follow from the burst unit
          start     = fire;
          start_irq = irq_r & (count_r > FP_CNT);
          elem.kind = sfe_pkg::KIND_TX;
          elem.data = sfe_pkg::HDR_MARK | 8'(take_n);
          elem.last = 1'b0;
          if (fire) begin
            await_nxt    = 1'b1;
            pay_left_nxt = '0;
            irq_nxt      = start_irq;
            head_nxt     = (head_sum >= DEPTH_W) ? AW'(head_sum - DEPTH_W) : AW'(head_sum);
            count_nxt    = count_r - CW'(take_n);
          end
        end
        sfe_pkg::CMD_SEL_RISE: begin
          elem.reset_pulse = rst_pend_r;
          if (fire) begin
            await_nxt    = 1'b0;
            pay_left_nxt = '0;
            rst_pend_nxt = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
    elem.irq = irq_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_up_r  <= 1'b0;
      await_r    <= 1'b0;
      pay_left_r <= '0;
      rst_pend_r <= 1'b0;
      irq_r      <= 1'b0;
      head_r     <= '0;
      tail_r     <= '0;
      count_r    <= '0;
    end else begin
      link_up_r  <= link_up_nxt;
      await_r    <= await_nxt;
      pay_left_r <= pay_left_nxt;
      rst_pend_r <= rst_pend_nxt;
      irq_r      <= irq_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      count_r    <= count_nxt;
    end
  end

endmodule

### design/sfe_burst.sv
// Transmit burst sequencer: payload bytes of a frame after its header.
module sfe_burst #(
  parameter int QUEUE_DEPTH   = 1024,
  parameter int FRAME_PAYLOAD = 7
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [$clog2(FRAME_PAYLOAD+1)-1:0] start_n,
  input  logic [$clog2(QUEUE_DEPTH)-1:0]     start_head,
  input  logic                               start_irq,
  input  logic                               emit,
  output logic                               busy,
  output sfe_pkg::elem_t                     elem,
  output logic [$clog2(QUEUE_DEPTH)-1:0]     rd_addr
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int IW = $clog2(FRAME_PAYLOAD + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(QUEUE_DEPTH - 1);
  localparam logic [IW-1:0] LAST_IDX  = IW'(FRAME_PAYLOAD);

  logic          busy_r, busy_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] nreal_r, nreal_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic          irq_r, irq_nxt;

  assign busy    = busy_r;
  assign rd_addr = ptr_r;

  always_comb begin
    elem.kind        = sfe_pkg::KIND_TX;
    elem.data        = sfe_pkg::PAD_BYTE;
    elem.use_mem     = (idx_r <= nreal_r);
    elem.last        = (idx_r == LAST_IDX);
    elem.irq         = irq_r;
    elem.accepted    = 1'b0;
    elem.reset_pulse = 1'b0;

    busy_nxt  = busy_r;
    idx_nxt   = idx_r;
    nreal_nxt = nreal_r;
    ptr_nxt   = ptr_r;
    irq_nxt   = irq_r;
    if (start) begin
      busy_nxt  = 1'b1;
      idx_nxt   = IW'(1);
      nreal_nxt = start_n;
      ptr_nxt   = start_head;
      irq_nxt   = start_irq;
    end else if (busy_r && emit) begin
      idx_nxt = idx_r + IW'(1);
      if (elem.use_mem) begin
        ptr_nxt = (ptr_r == LAST_ADDR) ? '0 : ptr_r + AW'(1);
      end
      if (elem.last) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    nreal_r <= nreal_nxt;
    ptr_r   <= ptr_nxt;
    irq_r   <= irq_nxt;
  end

endmodule

### design/spi_slave_frame_engine_core.sv
// Top level of the SPI slave frame engine: beat pipeline and send queue.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+-------------------------------------------
//  in_     | in  | in_valid / in_stall | in_command[1:0], in_data[7:0]
//  out_    | out | out_valid/out_stall | out_kind, out_byte_out, out_last,
//          |     |                     | out_irq_line, out_accepted, out_reset_pulse
//
// One input beat can be taken every cycle while in_stall is low; a result passes
// through the input register, the issue stage with queue read and the output
// register before it is presented.
// A select fall gives 1 + FRAME_PAYLOAD output beats, one per cycle unless stalled,
// and the next input beat waits in the input register until the last one issues.
// Reset is synchronous, active low, and clears control state; the send queue
// is not cleared, only written entries are ever read back.
// A stalled output holds its beat while the issue stage still fills behind it.
module spi_slave_frame_engine_core #(
  parameter int QUEUE_DEPTH   = 1024,
  parameter int FRAME_PAYLOAD = 7
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_command,
  input  logic [7:0] in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte_out,
  output logic       out_last,
  output logic       out_irq_line,
  output logic       out_accepted,
  output logic       out_reset_pulse
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int IW = $clog2(FRAME_PAYLOAD + 1);

  // input register
  logic       s0_vld_r;
  logic [1:0] s0_cmd_r;
  logic [7:0] s0_data_r;

  // issue stage: result plus the queue read in flight
  logic           s1_vld_r, s1_vld_nxt;
  sfe_pkg::elem_t s1_elem_r, s1_elem_nxt;

  // output register
  logic           out_vld_r;
  sfe_pkg::elem_t out_elem_r;
  logic [7:0]     out_byte_r;

  logic out_load, s1_free, s0_fire, burst_emit, in_take;

  sfe_pkg::elem_t proc_elem, burst_elem;
  logic           start, start_irq, burst_busy;
  logic [IW-1:0]  start_n;
  logic [AW-1:0]  start_head, rd_addr, wr_addr;
  logic           wr_en;
  logic [7:0]     wr_data, rd_data;

  assign out_load   = !out_vld_r || !out_stall;
  assign s1_free    = !s1_vld_r || out_load;
  assign burst_emit = burst_busy && s1_free;
  assign s0_fire    = s0_vld_r && !burst_busy && s1_free;
  assign in_stall   = s0_vld_r && !s0_fire;
  assign in_take    = in_valid && !in_stall;

  sfe_proc #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .FRAME_PAYLOAD(FRAME_PAYLOAD)
  ) u_proc (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (s0_fire),
    .command   (s0_cmd_r),
    .data      (s0_data_r),
    .elem      (proc_elem),
    .start     (start),
    .start_n   (start_n),
    .start_head(start_head),
    .start_irq (start_irq),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  sfe_burst #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .FRAME_PAYLOAD(FRAME_PAYLOAD)
  ) u_burst (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .start_n   (start_n),
    .start_head(start_head),
    .start_irq (start_irq),
    .emit      (burst_emit),
    .busy      (burst_busy),
    .elem      (burst_elem),
    .rd_addr   (rd_addr)
  );

  // Send queue; read data stays put while the issue stage holds.
  sfe_ram #(
    .WIDTH(8),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .re   (burst_emit && burst_elem.use_mem),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  always_comb begin
    s1_vld_nxt  = s1_vld_r;
    s1_elem_nxt = s1_elem_r;
    if (s1_free) begin
      s1_vld_nxt  = burst_emit || s0_fire;
      s1_elem_nxt = burst_busy ? burst_elem : proc_elem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r  <= 1'b0;
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_take) begin
        s0_vld_r <= 1'b1;
      end else if (s0_fire) begin
        s0_vld_r <= 1'b0;
      end
      s1_vld_r <= s1_vld_nxt;
      if (out_load) begin
        out_vld_r <= s1_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s0_cmd_r  <= in_command;
      s0_data_r <= in_data;
    end
    s1_elem_r <= s1_elem_nxt;
    if (out_load) begin
      out_elem_r <= s1_elem_r;
      out_byte_r <= s1_elem_r.use_mem ? rd_data : s1_elem_r.data;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_kind        = out_elem_r.kind;
  assign out_byte_out    = out_byte_r;
  assign out_last        = out_elem_r.last;
  assign out_irq_line    = out_elem_r.irq;
  assign out_accepted    = out_elem_r.accepted;
  assign out_reset_pulse = out_elem_r.reset_pulse;

  // Burst ends right after its closing beat issues.
  a_burst_end: assert property (@(posedge clk) disable iff (!rst_n)
    burst_emit && burst_elem.last |=> !burst_busy)
    else $error("burst still busy after last beat");

  // A queued host byte always leaves the pending line raised.
  a_acc_irq: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_elem_r.accepted |-> out_elem_r.irq)
    else $error("accepted byte without pending line");

  // Reset pulse only on a status beat.
  a_rst_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_elem_r.reset_pulse |-> out_elem_r.kind == sfe_pkg::KIND_STATUS)
    else $error("reset pulse on a data beat");

  // No event is processed while a burst still owns the issue stage.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    burst_busy |-> !start)
    else $error("event processed during burst");

endmodule

### bench/tb_spi_slave_frame_engine_core.sv
// Self-checking bench for the SPI slave frame engine: directed table, host run, random frames.
module tb_spi_slave_frame_engine_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUEUE_DEPTH   = 1024;
  localparam int FRAME_PAYLOAD = 7;
  localparam int HOST_RUN      = 20;
  localparam int RANDOM_BEATS  = 130;
  // Quiet cycles tolerated on both channels: sender gap + pipeline + receiver stall
  // + end drain, taken many times over.
  localparam int IDLE_LIMIT    = 2000;

  // One expected result beat, in the field order of the out_ channel.
  typedef struct packed {
    sfe_pkg::kind_t kind;
    logic [7:0]     byte_val;
    logic           last;
    logic           irq;
    logic           accepted;
    logic           reset_pulse;
  } beat_t;

  // Directed stimulus row; typed rows carry their own single expected beat.
  typedef struct packed {
    sfe_pkg::cmd_t cmd;
    logic [7:0]    data;
    logic          typed;
    beat_t         want;
  } row_t;

  localparam beat_t NO_BEAT   = '{sfe_pkg::KIND_PAYLOAD, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0};
  localparam beat_t ST_IDLE   = '{sfe_pkg::KIND_STATUS,  8'h00, 1'b1, 1'b0, 1'b0, 1'b0};
  localparam beat_t ST_QUEUED = '{sfe_pkg::KIND_STATUS,  8'h00, 1'b1, 1'b1, 1'b1, 1'b0};
  localparam beat_t ST_RESET  = '{sfe_pkg::KIND_STATUS,  8'h00, 1'b1, 1'b0, 1'b0, 1'b1};

  localparam int N_ROWS = 26;
  localparam row_t DIRECTED_ROWS [N_ROWS] = '{
    // first event after reset only brings the link up
    '{sfe_pkg::CMD_SEL_RISE,    8'hff, 1'b1, ST_IDLE},
    // master byte outside any frame is ignored
    '{sfe_pkg::CMD_MASTER_BYTE, 8'h53, 1'b1, ST_IDLE},
    '{sfe_pkg::CMD_HOST_BYTE,   8'h00, 1'b1, ST_QUEUED},
    '{sfe_pkg::CMD_HOST_BYTE,   8'hff, 1'b1, ST_QUEUED},
    '{sfe_pkg::CMD_HOST_BYTE,   8'ha5, 1'b0, NO_BEAT},
    // header 0x53, three queued bytes, four pad bytes; line drops
    '{sfe_pkg::CMD_SEL_FALL,    8'h00, 1'b0, NO_BEAT},
    // bad headers: wrong upper nibble, count 8, count 15
    '{sfe_pkg::CMD_MASTER_BYTE, 8'h48, 1'b1, ST_IDLE},
    '{sfe_pkg::CMD_MASTER_BYTE, 8'h58, 1'b1, ST_IDLE},
    '{sfe_pkg::CMD_MASTER_BYTE, 8'h5f, 1'b1, ST_IDLE},
    // host byte queued in the middle of a frame
    '{sfe_pkg::CMD_HOST_BYTE,   8'h3c, 1'b1, ST_QUEUED},
    // good header with full payload count clears the reset request
    '{sfe_pkg::CMD_MASTER_BYTE, 8'h57, 1'b0, NO_BEAT},
    '{sfe_pkg::CMD_MASTER_BYTE, 8'h00, 1'b0, NO_BEAT},
    '{sfe_pkg::CMD_MASTER_BYTE, 8'hff, 1'b0, NO_BEAT},
    '{sfe_pkg::CMD_MASTER_BYTE, 8'h80, 1'b0, NO_BEAT},
    '{sfe_pkg::CMD_MASTER_BYTE, 8'h01, 1'b0, NO_BEAT},
    '{sfe_pkg::CMD_MASTER_BYTE, 8'h7f, 1'b0, NO_BEAT},
    '{sfe_pkg::CMD_MASTER_BYTE, 8'haa, 1'b0, NO_BEAT},
    '{sfe_pkg::CMD_MASTER_BYTE, 8'h55, 1'b0, NO_BEAT},
    '{sfe_pkg::CMD_SEL_RISE,    8'h00, 1'b0, NO_BEAT},
    '{sfe_pkg::CMD_SEL_FALL,    8'hff, 1'b0, NO_BEAT},
    '{sfe_pkg::CMD_MASTER_BYTE, 8'h30, 1'b0, NO_BEAT},
    // frame end with a pending reset request
    '{sfe_pkg::CMD_SEL_RISE,    8'h00, 1'b1, ST_RESET},
    // empty queue: header 0x50 and all pad
    '{sfe_pkg::CMD_SEL_FALL,    8'h5a, 1'b0, NO_BEAT},
    // zero-length payload, then an extra byte that is ignored
    '{sfe_pkg::CMD_MASTER_BYTE, 8'h50, 1'b0, NO_BEAT},
    '{sfe_pkg::CMD_MASTER_BYTE, 8'h11, 1'b0, NO_BEAT},
    '{sfe_pkg::CMD_SEL_RISE,    8'ha5, 1'b0, NO_BEAT}
  };

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic [1:0] in_command = '0;
  logic [7:0] in_data   = '0;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [1:0] out_kind;
  logic [7:0] out_byte_out;
  logic       out_last;
  logic       out_irq_line;
  logic       out_accepted;
  logic       out_reset_pulse;

  wire in_fire  = in_valid && !in_stall;
  wire out_fire = out_valid && !out_stall;

  spi_slave_frame_engine_core #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .FRAME_PAYLOAD(FRAME_PAYLOAD)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_byte_out   (out_byte_out),
    .out_last       (out_last),
    .out_irq_line   (out_irq_line),
    .out_accepted   (out_accepted),
    .out_reset_pulse(out_reset_pulse)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Frame engine predictor: its own copy of the link, frame and queue state.
  // ---------------------------------------------------------------------------
  bit         linked;
  bit         want_header;
  int         payload_left;
  bit         reset_req;
  bit         irq_level;
  logic [7:0] host_fifo [$];

  beat_t      step_beats [$];    // beats caused by the current input beat
  beat_t      expected_beats [$];
  int         errors;
  int         beats_sent;
  bit         tx_calm;
  bit         rx_calm;

  function automatic beat_t make_beat(sfe_pkg::kind_t k, logic [7:0] b, bit l, bit a,
                                      bit r);
    make_beat = '{k, b, l, irq_level, a, r};
  endfunction

  function automatic void predict_engine(sfe_pkg::cmd_t cmd, logic [7:0] din);
    logic [7:0] tx [FRAME_PAYLOAD+1];
    int         cnt;
    bit         ok;
    step_beats.delete();
    if (!linked) begin
      linked = 1'b1;
      step_beats.push_back(make_beat(sfe_pkg::KIND_STATUS, 8'h00, 1'b1, 1'b0, 1'b0));
      return;
    end
    case (cmd)
      sfe_pkg::CMD_HOST_BYTE: begin
        // a full queue drops the byte but still raises the line
        ok = host_fifo.size() < QUEUE_DEPTH;
        if (ok) host_fifo.push_back(din);
        irq_level = 1'b1;
        step_beats.push_back(make_beat(sfe_pkg::KIND_STATUS, 8'h00, 1'b1, ok, 1'b0));
      end
      sfe_pkg::CMD_MASTER_BYTE: begin
        if (want_header) begin
          if ((din & sfe_pkg::HDR_MASK) == sfe_pkg::HDR_MARK
              && (din & sfe_pkg::CNT_MASK) <= FRAME_PAYLOAD) begin
            want_header  = 1'b0;
            payload_left = int'(din & sfe_pkg::CNT_MASK);
            reset_req    = 1'b0;
          end else begin
            reset_req = 1'b1;
          end
          step_beats.push_back(make_beat(sfe_pkg::KIND_STATUS, 8'h00, 1'b1, 1'b0, 1'b0));
        end else if (payload_left > 0) begin
          payload_left--;
          step_beats.push_back(make_beat(sfe_pkg::KIND_PAYLOAD, din, 1'b1, 1'b0, 1'b0));
        end else begin
          step_beats.push_back(make_beat(sfe_pkg::KIND_STATUS, 8'h00, 1'b1, 1'b0, 1'b0));
        end
      end
      sfe_pkg::CMD_SEL_FALL: begin
        want_header  = 1'b1;
        payload_left = 0;
        cnt   = host_fifo.size() > FRAME_PAYLOAD ? FRAME_PAYLOAD : host_fifo.size();
        tx[0] = sfe_pkg::HDR_MARK | 8'(cnt);
        for (int i = 1; i <= FRAME_PAYLOAD; i++)
          tx[i] = host_fifo.size() > 0 ? host_fifo.pop_front() : sfe_pkg::PAD_BYTE;
        // line level is reported after the pops on every frame beat
        if (host_fifo.size() == 0) irq_level = 1'b0;
        for (int i = 0; i <= FRAME_PAYLOAD; i++)
          step_beats.push_back(make_beat(sfe_pkg::KIND_TX, tx[i], i == FRAME_PAYLOAD,
                                         1'b0, 1'b0));
      end
      default: begin
        step_beats.push_back(make_beat(sfe_pkg::KIND_STATUS, 8'h00, 1'b1, 1'b0, reset_req));
        want_header  = 1'b0;
        payload_left = 0;
        reset_req    = 1'b0;
      end
    endcase
  endfunction

  // Wait length for one beat; calm stretches run with no idling at all.
  function automatic int draw_wait(inout bit calm);
    if ($urandom_range(0, 15) == 0) calm = !calm;
    draw_wait = calm ? 0 : $urandom_range(0, 9);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: one input beat, predicted when it is taken.
  // ---------------------------------------------------------------------------
  task automatic send_beat(sfe_pkg::cmd_t cmd, logic [7:0] din, bit typed = 1'b0,
                           beat_t want = NO_BEAT);
    int gap;
    gap = draw_wait(tx_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_data    <= din;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // beat taken at this edge
    predict_engine(cmd, din);
    if (typed) expected_beats.push_back(want);
    else foreach (step_beats[i]) expected_beats.push_back(step_beats[i]);
    beats_sent++;
  endtask

  // Hold the sender off until every expected beat has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_beats.size() != 0) @(posedge clk);
  endtask

  // One frame: select fall, header (sometimes bad), payload, mostly a select rise.
  // host_pct mixes host bytes into the frame.
  task automatic run_frame(int host_pct);
    int         n;
    int         extra;
    logic [7:0] hdr;
    bit         bad;
    send_beat(sfe_pkg::CMD_SEL_FALL, 8'($urandom));
    n   = $urandom_range(0, FRAME_PAYLOAD);
    bad = 1'b0;
    case ($urandom_range(0, 9))
      0: begin hdr = 8'($urandom); bad = 1'b1; end
      1: begin hdr = {4'h5, 4'($urandom_range(FRAME_PAYLOAD + 1, 15))}; bad = 1'b1; end
      default: hdr = sfe_pkg::HDR_MARK | 8'(n);
    endcase
    send_beat(sfe_pkg::CMD_MASTER_BYTE, hdr);
    // the block keeps hunting for a header after a bad one
    if (bad && $urandom_range(0, 1) == 1)
      send_beat(sfe_pkg::CMD_MASTER_BYTE, sfe_pkg::HDR_MARK | 8'(n));
    extra = $urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0;
    for (int i = 0; i < n + extra; i++) begin
      if ($urandom_range(0, 99) < host_pct) send_beat(sfe_pkg::CMD_HOST_BYTE, 8'($urandom));
      send_beat(sfe_pkg::CMD_MASTER_BYTE, 8'($urandom));
    end
    // a few frames are left open and cut by the next fall
    if ($urandom_range(0, 9) != 0) send_beat(sfe_pkg::CMD_SEL_RISE, 8'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall per beat, and the field compare.
  // ---------------------------------------------------------------------------
  int    stall_left;
  beat_t got_want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else if (out_fire) begin
      stall_left = draw_wait(rx_calm);
      if (stall_left > 0) out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      if (stall_left == 0) out_stall <= 1'b0;
    end
  end

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_fire) begin
      if (expected_beats.size() == 0) begin
        $error("result beat with nothing expected: kind %0d byte 0x%02h",
               out_kind, out_byte_out);
        errors++;
      end else begin
        got_want = expected_beats.pop_front();
        check_field("kind",        got_want.kind,        out_kind);
        check_field("byte_out",    got_want.byte_val,    out_byte_out);
        check_field("last",        got_want.last,        out_last);
        check_field("irq_line",    got_want.irq,         out_irq_line);
        check_field("accepted",    got_want.accepted,    out_accepted);
        check_field("reset_pulse", got_want.reset_pulse, out_reset_pulse);
      end
    end
  end

  // Watchdog: too long with neither channel moving ends the run.
  int quiet_cycles;

  always @(posedge clk) begin
    if (!rst_n || in_fire || out_fire) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    int rand_start;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (DIRECTED_ROWS[r])
      send_beat(DIRECTED_ROWS[r].cmd, DIRECTED_ROWS[r].data,
                DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
    drain_results();

    // a run of host bytes, then frames until the send queue is empty
    for (int i = 0; i < HOST_RUN; i++)
      send_beat(sfe_pkg::CMD_HOST_BYTE, 8'($urandom));
    while (host_fifo.size() > 0) run_frame(0);
    drain_results();

    // random part: mostly well-formed frames, some loose beats
    rand_start = beats_sent;
    while (beats_sent < rand_start + RANDOM_BEATS) begin
      if ($urandom_range(0, 9) < 7) run_frame(30);
      else send_beat(sfe_pkg::cmd_t'($urandom_range(0, 3)), 8'($urandom));
    end

    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

### filelist.f
design/sfe_pkg.sv
design/sfe_ram.sv
design/sfe_proc.sv
design/sfe_burst.sv
design/spi_slave_frame_engine_core.sv
bench/tb_spi_slave_frame_engine_core.sv
